### design/hpt_pkg.sv
// Shared constants, codes and types for the hashed page table insert block.
package hpt_pkg;

    localparam int SLOTS_PER_GROUP     = 8;
    localparam int SLOT_W              = $clog2(SLOTS_PER_GROUP);
    localparam int DEF_BASE_GROUP_BITS = 11;
    localparam int DEF_MAX_SIZE_CODE   = 2;

    localparam int EA_W     = 32;
    localparam int PA_W     = 44;
    localparam int MODE_W   = 9;
    localparam int ADDR46_W = 46;
    localparam int TAG_W    = 16;
    localparam int ENTRY_W  = TAG_W + 1;
    localparam int PPN_W    = 32;
    localparam int FLAGS_W  = 7;
    localparam int PROT_W   = 2;
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 2;
    localparam int SEG_W    = 11;
    localparam int PAGE_W   = 16;
    localparam int HASH_W   = 32;
    localparam int GROUP_SHIFT   = 7;
    localparam int PAGE_OFFSET_W = 12;

    localparam logic [SEG_W-1:0] SEGMENT_OFFSET = 11'h400;
    localparam logic [ADDR46_W-1:0] TABLE_BASE_RST = 46'd134217728;

    localparam int PDATA_W = 64;
    localparam int PADDR_W = 4;

    localparam logic REG_TABLE_BASE = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_WRITE = 4'b1000
    } hpt_state_t;

endpackage

### design/hpt_if.sv
// Request and result channel interfaces for the hashed page table insert block.
interface hpt_req_if
    import hpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [EA_W-1:0]   effective_address;
    logic [PA_W-1:0]   physical_address;
    logic [MODE_W-1:0] mode_bits;

    modport source (output valid, effective_address, physical_address, mode_bits,
                    input ready);
    modport sink   (input valid, effective_address, physical_address, mode_bits,
                    output ready);
endinterface

interface hpt_res_if
    import hpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ADDR46_W-1:0] group_address;
    logic [SLOT_W-1:0]   slot_index;
    logic [KIND_W-1:0]   slot_kind;
    logic [TAG_W-1:0]    pte_tag;
    logic [PPN_W-1:0]    pte_page_number;
    logic [FLAGS_W-1:0]  pte_flags;
    logic [PROT_W-1:0]   pte_protection;
    logic [EA_W-1:0]     invalidate_address;

    modport source (output valid, group_address, slot_index, slot_kind, pte_tag,
                    pte_page_number, pte_flags, pte_protection, invalidate_address,
                    input ready);
    modport sink   (input valid, group_address, slot_index, slot_kind, pte_tag,
                    pte_page_number, pte_flags, pte_protection, invalidate_address,
                    output ready);
endinterface

### design/hashed_page_table_insert.sv
// Hashed page table insert: tag store, slot scan sequencer and APB registers.
// Flow: each accepted request is scanned over its group and then written; no new request
// is taken until the write commits, which waits while the result output is stalled. One
// tag compare per cycle over the 8 slots through the single port of the tag memory.
// Reset: after rst_n releases, a clearing pass of 2^(BASE_GROUP_BITS+MAX_SIZE_CODE+3)
// cycles (65536 by default) zeroes the tag memory; requests wait, APB writes proceed.
module hashed_page_table_insert
    import hpt_pkg::*;
#(
    parameter int BASE_GROUP_BITS = DEF_BASE_GROUP_BITS,
    parameter int MAX_SIZE_CODE   = DEF_MAX_SIZE_CODE
)
(
    input  logic               clk,
    input  logic               rst_n,
    hpt_req_if.sink            req,
    hpt_res_if.source          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int GROUP_W = BASE_GROUP_BITS + MAX_SIZE_CODE;
    localparam int ADDR_W  = GROUP_W + SLOT_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int SIZE_W  = ($clog2(MAX_SIZE_CODE + 1) > CODE_W) ?
                             $clog2(MAX_SIZE_CODE + 1) : CODE_W;
    localparam int STEP_W  = SLOT_W + 1;

    hpt_state_t state_reg, state_next;

    logic [ADDR46_W-1:0] table_base_reg;
    logic [CODE_W-1:0]   size_code_reg;

    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SLOT_W-1:0]   victim_reg, victim_next;

    logic                match_found_reg, match_found_next;
    logic [SLOT_W-1:0]   match_slot_reg, match_slot_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;

    logic [TAG_W-1:0]    tag_reg;
    logic [GROUP_W-1:0]  group_reg;
    logic [ADDR46_W-1:0] gaddr_reg;
    logic [PPN_W-1:0]    ppn_reg;
    logic [FLAGS_W-1:0]  flags_reg;
    logic [PROT_W-1:0]   prot_reg;
    logic [EA_W-1:0]     ea_reg;

    logic                res_valid_reg, res_valid_next;
    logic [ADDR46_W-1:0] res_gaddr_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [KIND_W-1:0]   res_kind_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic [PPN_W-1:0]    res_ppn_reg;
    logic [FLAGS_W-1:0]  res_flags_reg;
    logic [PROT_W-1:0]   res_prot_reg;
    logic [EA_W-1:0]     res_ea_reg;

    logic [ENTRY_W-1:0]  mem [DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]   mem_addr;
    logic                mem_we;
    logic [ENTRY_W-1:0]  mem_wdata;

    logic                cfg_write;
    logic                accept;
    logic                commit;

    logic [SEG_W-1:0]    segment;
    logic [PAGE_W-1:0]   page;
    logic [TAG_W-1:0]    new_tag;
    logic [SIZE_W-1:0]   size_code_ext;
    logic [SIZE_W-1:0]   size_eff;
    logic [SIZE_W-1:0]   size_shrink;
    logic [GROUP_W-1:0]  group_mask;
    logic [HASH_W-1:0]   hash_full;
    logic [GROUP_W-1:0]  group_new;
    logic [ADDR46_W-1:0] gaddr_new;

    logic [SLOT_W-1:0]   scan_slot;
    logic [SLOT_W-1:0]   pick_slot;
    logic [KIND_W-1:0]   pick_kind;

    // APB registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= TABLE_BASE_RST;
            size_code_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[PADDR_W-1])
                REG_TABLE_BASE: table_base_reg <= pwdata[ADDR46_W-1:0];
                REG_TABLE_SIZE: size_code_reg  <= pwdata[CODE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1])
            REG_TABLE_BASE: prdata = PDATA_W'(table_base_reg);
            REG_TABLE_SIZE: prdata = PDATA_W'(size_code_reg);
            default:        prdata = '0;
        endcase
    end

    // Request decode: segment id, page index, tag and group hash
    assign segment = SEG_W'(req.effective_address[EA_W-1:28]) + SEGMENT_OFFSET;
    assign page    = req.effective_address[27:PAGE_OFFSET_W];
    assign new_tag = {segment, page[PAGE_W-1:PAGE_W-5]};

    assign size_code_ext = SIZE_W'(size_code_reg);
    assign size_eff      = (size_code_ext > SIZE_W'(MAX_SIZE_CODE)) ?
                           SIZE_W'(MAX_SIZE_CODE) : size_code_ext;
    assign size_shrink   = SIZE_W'(MAX_SIZE_CODE) - size_eff;
    assign group_mask    = {GROUP_W{1'b1}} >> size_shrink;
    assign hash_full     = HASH_W'(segment) ^ HASH_W'(page);
    assign group_new     = hash_full[GROUP_W-1:0] & group_mask;
    assign gaddr_new     = table_base_reg | ADDR46_W'(size_eff)
                         | ADDR46_W'({group_new, {GROUP_SHIFT{1'b0}}});

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == ST_WRITE) && (!res_valid_reg || res.ready);

    // Slot choice: matching tag, then first free, then round-robin victim
    always_comb
    begin
        if (match_found_reg)
        begin
            pick_slot = match_slot_reg;
            pick_kind = KIND_MATCH;
        end
        else if (free_found_reg)
        begin
            pick_slot = free_slot_reg;
            pick_kind = KIND_FREE;
        end
        else
        begin
            pick_slot = victim_reg;
            pick_kind = KIND_VICTIM;
        end
    end

    // Tag memory port
    always_comb
    begin
        mem_addr  = {group_reg, step_reg[SLOT_W-1:0]};
        mem_we    = 1'b0;
        mem_wdata = {1'b1, tag_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            ST_WRITE:
            begin
                mem_addr = {group_reg, pick_slot};
                mem_we   = commit;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // Sequencer
    assign scan_slot = SLOT_W'(step_reg - STEP_W'(1));

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        step_next        = step_reg;
        victim_next      = victim_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next       = ST_SCAN;
                    step_next        = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (step_reg != '0)
                begin
                    if (rd_data_reg[TAG_W] && (rd_data_reg[TAG_W-1:0] == tag_reg)
                        && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_slot_next  = scan_slot;
                    end
                    if (!rd_data_reg[TAG_W] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = scan_slot;
                    end
                end
                if (step_reg == STEP_W'(SLOTS_PER_GROUP))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_WRITE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                    if (pick_kind == KIND_VICTIM)
                    begin
                        victim_next = victim_reg + SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            step_reg        <= '0;
            victim_reg      <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            step_reg        <= step_next;
            victim_reg      <= victim_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        if (accept)
        begin
            tag_reg   <= new_tag;
            group_reg <= group_new;
            gaddr_reg <= gaddr_new;
            ppn_reg   <= req.physical_address[PA_W-1:PAGE_OFFSET_W];
            flags_reg <= req.mode_bits[MODE_W-1:PROT_W];
            prot_reg  <= req.mode_bits[PROT_W-1:0];
            ea_reg    <= req.effective_address;
        end
        if (commit)
        begin
            res_gaddr_reg <= gaddr_reg;
            res_slot_reg  <= pick_slot;
            res_kind_reg  <= pick_kind;
            res_tag_reg   <= tag_reg;
            res_ppn_reg   <= ppn_reg;
            res_flags_reg <= flags_reg;
            res_prot_reg  <= prot_reg;
            res_ea_reg    <= ea_reg;
        end
    end

    assign res.valid              = res_valid_reg;
    assign res.group_address      = res_gaddr_reg;
    assign res.slot_index         = res_slot_reg;
    assign res.slot_kind          = res_kind_reg;
    assign res.pte_tag            = res_tag_reg;
    assign res.pte_page_number    = res_ppn_reg;
    assign res.pte_flags          = res_flags_reg;
    assign res.pte_protection     = res_prot_reg;
    assign res.invalidate_address = res_ea_reg;

endmodule

### tb/tb.sv
// Testbench for the hashed page table insert block: group hash, slot choice and entry fields.
module tb;
    import hpt_pkg::*;

    localparam int GROUP_BITS_MAX = DEF_BASE_GROUP_BITS + DEF_MAX_SIZE_CODE;
    localparam int STORE_DEPTH    = (1 << GROUP_BITS_MAX) * SLOTS_PER_GROUP;
    localparam int HOT_GROUPS     = 4;

    typedef struct {
        logic [ADDR46_W-1:0] group_address;
        logic [SLOT_W-1:0]   slot_index;
        logic [KIND_W-1:0]   slot_kind;
        logic [TAG_W-1:0]    pte_tag;
        logic [PPN_W-1:0]    pte_page_number;
        logic [FLAGS_W-1:0]  pte_flags;
        logic [PROT_W-1:0]   pte_protection;
        logic [EA_W-1:0]     invalidate_address;
    } pte_insert_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    hpt_req_if req();
    hpt_res_if res();

    hashed_page_table_insert dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pte_insert_t               pending_inserts[$];
    logic [ENTRY_W-1:0]        slot_store [STORE_DEPTH];
    logic [SLOT_W-1:0]         victim_ptr;
    logic [ADDR46_W-1:0]       base_reg;
    logic [CODE_W-1:0]         size_reg;
    logic [GROUP_BITS_MAX-1:0] hot_groups [HOT_GROUPS];
    logic                      no_idle;
    int                        mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", field, got, want));
    endtask

    function automatic pte_insert_t predict_insert(input logic [EA_W-1:0] ea,
                                                   input logic [PA_W-1:0] pa,
                                                   input logic [MODE_W-1:0] mode);
        logic [CODE_W-1:0]         size;
        logic [SEG_W-1:0]          seg;
        logic [PAGE_W-1:0]         page;
        logic [PAGE_W-1:0]         hash;
        logic [TAG_W-1:0]          tag;
        logic [GROUP_BITS_MAX-1:0] group;
        logic [SLOT_W-1:0]         slot;
        logic [KIND_W-1:0]         kind;
        logic                      found;
        int                        first;
        pte_insert_t               r;
        size  = (size_reg > DEF_MAX_SIZE_CODE) ? CODE_W'(DEF_MAX_SIZE_CODE) : size_reg;
        seg   = SEG_W'(ea[31:28]) + SEGMENT_OFFSET;
        page  = ea[27:12];
        tag   = {seg, page[15:11]};
        hash  = PAGE_W'(seg) ^ page;
        group = GROUP_BITS_MAX'(hash)
              & GROUP_BITS_MAX'((1 << (DEF_BASE_GROUP_BITS + int'(size))) - 1);
        first = int'(group) * SLOTS_PER_GROUP;
        found = 1'b0;
        slot  = '0;
        kind  = KIND_VICTIM;
        for (int i = 0; i < SLOTS_PER_GROUP; i++)
            if (!found && slot_store[first + i][TAG_W] && slot_store[first + i][TAG_W-1:0] == tag)
            begin
                slot  = SLOT_W'(i);
                kind  = KIND_MATCH;
                found = 1'b1;
            end
        for (int i = 0; i < SLOTS_PER_GROUP; i++)
            if (!found && !slot_store[first + i][TAG_W])
            begin
                slot  = SLOT_W'(i);
                kind  = KIND_FREE;
                found = 1'b1;
            end
        if (!found)
        begin
            slot       = victim_ptr;
            victim_ptr = victim_ptr + 1'b1;
        end
        slot_store[first + int'(slot)] = {1'b1, tag};
        r.group_address      = base_reg | ADDR46_W'(size) | (ADDR46_W'(group) << GROUP_SHIFT);
        r.slot_index         = slot;
        r.slot_kind          = kind;
        r.pte_tag            = tag;
        r.pte_page_number    = pa[PA_W-1:PAGE_OFFSET_W];
        r.pte_flags          = mode[MODE_W-1:PROT_W];
        r.pte_protection     = mode[PROT_W-1:0];
        r.invalidate_address = ea;
        return r;
    endfunction

    // Address in the given group; tsel picks one of 128 tags that hash to it.
    function automatic logic [EA_W-1:0] make_ea(input logic [GROUP_BITS_MAX-1:0] grp,
                                               input logic [6:0] tsel);
        logic [SEG_W-1:0]  seg;
        logic [PAGE_W-1:0] page;
        seg  = SEG_W'(tsel[3:0]) + SEGMENT_OFFSET;
        page = {tsel[6:4], grp[12:11], grp[10:0] ^ seg[10:0]};
        return {tsel[3:0], page, 12'($urandom)};
    endfunction

    task automatic send_request(input logic [EA_W-1:0] ea, input logic [PA_W-1:0] pa,
                                input logic [MODE_W-1:0] mode);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.effective_address = ea;
        req.physical_address  = pa;
        req.mode_bits         = mode;
        req.valid             = 1'b1;
        do @(posedge clk); while (!req.ready);
        pending_inserts.push_back(predict_insert(ea, pa, mode));
        @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [EA_W-1:0] ea;
        if ($urandom_range(0, 3) != 0)
            ea = make_ea(hot_groups[$urandom_range(0, HOT_GROUPS - 1)],
                         7'($urandom_range(0, 11)));
        else
            ea = $urandom;
        send_request(ea, PA_W'({$urandom, $urandom}), MODE_W'($urandom));
    endtask

    task automatic drain_inserts();
        req.valid = 1'b0;
        while (pending_inserts.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic reg_idx, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(reg_idx) << 3;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (reg_idx)
            REG_TABLE_BASE: base_reg = value[ADDR46_W-1:0];
            REG_TABLE_SIZE: size_reg = value[CODE_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_register(input logic reg_idx, output logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = PADDR_W'(reg_idx) << 3;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_registers();
        logic [PDATA_W-1:0] value;
        read_register(REG_TABLE_BASE, value);
        check_field("table_base readback", 64'(value[ADDR46_W-1:0]), 64'(base_reg));
        read_register(REG_TABLE_SIZE, value);
        check_field("table_size_code readback", 64'(value[CODE_W-1:0]), 64'(size_reg));
    endtask

    task automatic set_table(input logic [ADDR46_W-1:0] base, input logic [CODE_W-1:0] size);
        write_register(REG_TABLE_BASE, PDATA_W'(base));
        write_register(REG_TABLE_SIZE, PDATA_W'(size));
        check_registers();
    endtask

    task automatic test_directed_corners();
        logic [GROUP_BITS_MAX-1:0] grp;
        check_registers();
        send_request('0, '0, '0);
        send_request('1, '1, '1);
        send_request('0, {PA_W/2{2'b01}}, 9'h155);
        grp = GROUP_BITS_MAX'(13'h0123);
        // fill one group, then evict twice, then hit the survivor and a lost tag
        for (int t = 0; t < 10; t++)
            send_request(make_ea(grp, 7'(t)), {PA_W/2{2'b10}}, 9'h0AA);
        send_request(make_ea(grp, 7'd8), PA_W'({$urandom, $urandom}), MODE_W'($urandom));
        send_request(make_ea(grp, 7'd0), PA_W'({$urandom, $urandom}), MODE_W'($urandom));
        drain_inserts();
    endtask

    task automatic test_size_code_sweep();
        logic [ADDR46_W-1:0] bases [5];
        logic [CODE_W-1:0]   sizes [5];
        bases = '{'0, '1, ADDR46_W'({$urandom, $urandom}) << 9,
                  ADDR46_W'({$urandom, $urandom}) << 10, '1};
        sizes = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0};
        for (int p = 0; p < 5; p++)
        begin
            set_table(bases[p], sizes[p]);
            repeat (120) send_random_request();
            drain_inserts();
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        set_table(ADDR46_W'({$urandom, $urandom}), CODE_W'($urandom_range(0, 3)));
        repeat (150) send_random_request();
        drain_inserts();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
        begin
            set_table(ADDR46_W'({$urandom, $urandom}), CODE_W'($urandom_range(0, 3)));
            repeat (75) send_random_request();
            drain_inserts();
        end
    endtask

    initial
    begin : result_checker
        pte_insert_t want;
        int          stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready = 1'b1;
            do @(posedge clk); while (!res.valid);
            if (pending_inserts.size() == 0)
                report_mismatch("result transaction with nothing pending");
            else
            begin
                want = pending_inserts.pop_front();
                check_field("group_address", 64'(res.group_address),
                            64'(want.group_address));
                check_field("slot_index", 64'(res.slot_index), 64'(want.slot_index));
                check_field("slot_kind", 64'(res.slot_kind), 64'(want.slot_kind));
                check_field("pte_tag", 64'(res.pte_tag), 64'(want.pte_tag));
                check_field("pte_page_number", 64'(res.pte_page_number),
                            64'(want.pte_page_number));
                check_field("pte_flags", 64'(res.pte_flags), 64'(want.pte_flags));
                check_field("pte_protection", 64'(res.pte_protection),
                            64'(want.pte_protection));
                check_field("invalidate_address", 64'(res.invalidate_address),
                            64'(want.invalidate_address));
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req.valid             = 1'b0;
        req.effective_address = '0;
        req.physical_address  = '0;
        req.mode_bits         = '0;
        no_idle               = 1'b0;
        mismatches            = 0;
        victim_ptr            = '0;
        base_reg              = TABLE_BASE_RST;
        size_reg              = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
            slot_store[i] = '0;
        for (int i = 0; i < HOT_GROUPS; i++)
            hot_groups[i] = GROUP_BITS_MAX'($urandom);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_size_code_sweep();
        test_back_to_back();
        test_random_traffic();

        drain_inserts();
        repeat (12) @(posedge clk);
        if (pending_inserts.size() != 0)
            report_mismatch("results still pending at end of run");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
design/hpt_pkg.sv
design/hpt_if.sv
design/hashed_page_table_insert.sv
tb/tb.sv
